// ----- rtl/rtb_pkg.sv -----
// Package for the repeating timer bank: field widths, result codes and the
// layout of one stored timer entry.
// No dependencies; every other file of the block but rtb_ram refers to it by scoped names.
package rtb_pkg;

   // Field widths of the request and response channels.
   localparam int OP_W      = 1;
   localparam int PERIOD_W  = 32;
   localparam int COUNT_W   = 16;
   localparam int DT_W      = 32;
   localparam int KIND_W    = 2;
   localparam int ID_W      = 16;

   // Accumulated time is held with two guard bits and saturates at all ones.
   localparam int ACC_W     = 34;

   // At most this many firings are reported for one tick.
   localparam int RESULT_CAP = 16;
   localparam int NEMIT_W    = 5;

   // Request operation codes.
   localparam logic [OP_W-1:0] OP_CREATE = 1'b0;
   localparam logic [OP_W-1:0] OP_TICK   = 1'b1;

   // Response event codes.
   localparam logic [KIND_W-1:0] KIND_CREATED  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_IDLE     = 2'd3;

   // One timer as it sits in the entry memory.
   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [ACC_W-1:0]    acc;
      logic [COUNT_W-1:0]  count;
      logic [ID_W-1:0]     id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Outcome of one pass of the shared update unit over a timer.
   typedef struct packed {
      logic               fire;
      logic               gone;
      logic [ACC_W-1:0]   acc;
      logic [COUNT_W-1:0] count;
   } update_type;

endpackage

// ----- rtl/rtb_if.sv -----
// Valid/ready channel interfaces for the repeating timer bank.
// Depends on rtb_pkg for the field widths.

// Request channel: create a timer or advance all timers.
interface rtb_req_if;
   logic                         valid;
   logic                         ready;
   logic [rtb_pkg::OP_W-1:0]     op;
   logic [rtb_pkg::PERIOD_W-1:0] period;
   logic [rtb_pkg::COUNT_W-1:0]  repeat_count;
   logic [rtb_pkg::DT_W-1:0]     elapsed;

   modport source (output valid, op, period, repeat_count, elapsed, input ready);
   modport sink   (input valid, op, period, repeat_count, elapsed, output ready);
endinterface

// Response channel: one event per create request, one or more for a tick.
interface rtb_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rtb_pkg::KIND_W-1:0] event_kind;
   logic [rtb_pkg::ID_W-1:0]   timer_id;
   logic                       removed;
   logic                       last;

   modport source (output valid, event_kind, timer_id, removed, last, input ready);
   modport sink   (input valid, event_kind, timer_id, removed, last, output ready);
endinterface

// ----- rtl/rtb_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module rtb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rtb_alu.sv -----
// Shared update unit: adds the tick time to one timer, saturates, compares
// against the period and works out the new accumulated time and count.
// Depends on rtb_pkg.
module rtb_alu (
   input  rtb_pkg::entry_type            entry,
   input  logic [rtb_pkg::DT_W-1:0]      dt,
   output rtb_pkg::update_type           result
);

   logic [rtb_pkg::ACC_W:0]   sum;
   logic [rtb_pkg::ACC_W-1:0] acc_sat;
   logic [rtb_pkg::ACC_W:0]   diff;
   logic                      fire;
   logic                      gone;

   // Add with saturation at the top of the accumulator range.
   assign sum     = {1'b0, entry.acc} + (rtb_pkg::ACC_W + 1)'(dt);
   assign acc_sat = sum[rtb_pkg::ACC_W] ? {rtb_pkg::ACC_W{1'b1}} : sum[rtb_pkg::ACC_W-1:0];

   // One subtractor serves as both the compare and the period removal.
   assign diff = {1'b0, acc_sat} - (rtb_pkg::ACC_W + 1)'(entry.period);
   assign fire = ~diff[rtb_pkg::ACC_W];
   assign gone = fire && (entry.count == '0);

   always_comb begin
      result.fire  = fire;
      result.gone  = gone;
      result.acc   = acc_sat;
      result.count = entry.count;
      if (fire && !gone) begin
         result.acc   = diff[rtb_pkg::ACC_W-1:0];
         result.count = entry.count - rtb_pkg::COUNT_W'(1);
      end
   end

endmodule

// ----- rtl/repeating_timer_bank.sv -----
// Repeating timer bank: a create request is answered from the create state, and the next
// request is taken once the bank is back in idle. A tick request walks the live timers one
// per cycle through the shared update unit, except while a firing waits on a full response
// register; its final response is registered from the end state, after which the next
// request is taken. A full response register also holds the create and end states back.
// Reset empties the list and restarts ids at zero; the memory keeps its data.
module repeating_timer_bank #(
   parameter int NUM_TIMERS = 16
) (
   input  logic      clock,
   input  logic      reset,
   rtb_req_if.sink   req_chan,
   rtb_rsp_if.source rsp_chan
);

   localparam int IW = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_CREATE = 2'd1;
   localparam logic [1:0] S_TICK   = 2'd2;
   localparam logic [1:0] S_END    = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [CW-1:0]                live_ff, live_in;
   logic [rtb_pkg::ID_W-1:0]     next_id_ff, next_id_in;
   logic [rtb_pkg::PERIOD_W-1:0] req_period_ff, req_period_in;
   logic [rtb_pkg::COUNT_W-1:0]  req_reps_ff, req_reps_in;
   logic [rtb_pkg::DT_W-1:0]     dt_ff, dt_in;
   logic [CW-1:0]                rd_ff, rd_in;
   logic [CW-1:0]                wr_ff, wr_in;
   logic                         dvld_ff, dvld_in;
   logic [rtb_pkg::NEMIT_W-1:0]  nemit_ff, nemit_in;
   logic                         pend_ff, pend_in;
   logic [rtb_pkg::ID_W-1:0]     pend_id_ff, pend_id_in;
   logic                         pend_rem_ff, pend_rem_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rtb_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [rtb_pkg::ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                         rsp_removed_ff, rsp_removed_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         ram_we;
   logic [IW-1:0]                ram_waddr;
   rtb_pkg::entry_type           ram_wdata;
   logic                         ram_re;
   logic [IW-1:0]                ram_raddr;
   rtb_pkg::entry_type           ram_rdata;
   rtb_pkg::update_type          upd;

   logic                         out_free;
   logic                         emit;
   logic                         stall;

   // Entry memory holding the compacted timer list.
   rtb_ram #(
      .WIDTH (rtb_pkg::ENTRY_W),
      .DEPTH (NUM_TIMERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Shared add, compare and subtract unit.
   rtb_alu u_alu (
      .entry  (ram_rdata),
      .dt     (dt_ff),
      .result (upd)
   );

   assign req_chan.ready      = (state_ff == S_IDLE) && !reset;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.event_kind = rsp_kind_ff;
   assign rsp_chan.timer_id   = rsp_id_ff;
   assign rsp_chan.removed    = rsp_removed_ff;
   assign rsp_chan.last       = rsp_last_ff;

   // The response register can take a new result this cycle.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // A firing is reported while under the cap; the held firing must then leave.
   assign emit  = (state_ff == S_TICK) && dvld_ff && upd.fire &&
                  (nemit_ff < rtb_pkg::NEMIT_W'(rtb_pkg::RESULT_CAP));
   assign stall = emit && pend_ff && !out_free;

   // Sequencer and datapath control.
   always_comb begin
      state_in       = state_ff;
      live_in        = live_ff;
      next_id_in     = next_id_ff;
      req_period_in  = req_period_ff;
      req_reps_in    = req_reps_ff;
      dt_in          = dt_ff;
      rd_in          = rd_ff;
      wr_in          = wr_ff;
      dvld_in        = dvld_ff;
      nemit_in       = nemit_ff;
      pend_in        = pend_ff;
      pend_id_in     = pend_id_ff;
      pend_rem_in    = pend_rem_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_last_in    = rsp_last_ff;
      ram_we         = 1'b0;
      ram_waddr      = wr_ff[IW-1:0];
      ram_wdata      = ram_rdata;
      ram_re         = 1'b0;
      ram_raddr      = rd_ff[IW-1:0];

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               req_period_in = req_chan.period;
               req_reps_in   = req_chan.repeat_count;
               dt_in         = req_chan.elapsed;
               rd_in         = '0;
               wr_in         = '0;
               dvld_in       = 1'b0;
               nemit_in      = '0;
               pend_in       = 1'b0;
               state_in      = (req_chan.op == rtb_pkg::OP_TICK) ? S_TICK : S_CREATE;
            end
         end

         // Append the new timer at the end of the list, or reject when full.
         S_CREATE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_removed_in = 1'b0;
               rsp_last_in    = 1'b1;
               if (live_ff == CW'(NUM_TIMERS)) begin
                  rsp_kind_in = rtb_pkg::KIND_REJECTED;
                  rsp_id_in   = '0;
               end else begin
                  ram_we           = 1'b1;
                  ram_waddr        = live_ff[IW-1:0];
                  ram_wdata.period = req_period_ff;
                  ram_wdata.acc    = '0;
                  ram_wdata.count  = req_reps_ff;
                  ram_wdata.id     = next_id_ff;
                  rsp_kind_in      = rtb_pkg::KIND_CREATED;
                  rsp_id_in        = next_id_ff;
                  next_id_in       = next_id_ff + rtb_pkg::ID_W'(1);
                  live_in          = live_ff + CW'(1);
               end
               state_in = S_IDLE;
            end
         end

         // Read one timer a cycle unless stalled, update the one read before and write it
         // back compacted; each reported firing is held until the next one
         // shows whether it is the final result.
         S_TICK: begin
            if (!stall) begin
               if (dvld_ff) begin
                  if (!upd.gone) begin
                     ram_we          = 1'b1;
                     ram_wdata.acc   = upd.acc;
                     ram_wdata.count = upd.count;
                     wr_in           = wr_ff + CW'(1);
                  end
                  if (emit) begin
                     if (pend_ff) begin
                        rsp_valid_in   = 1'b1;
                        rsp_kind_in    = rtb_pkg::KIND_FIRED;
                        rsp_id_in      = pend_id_ff;
                        rsp_removed_in = pend_rem_ff;
                        rsp_last_in    = 1'b0;
                     end
                     pend_in     = 1'b1;
                     pend_id_in  = ram_rdata.id;
                     pend_rem_in = upd.gone;
                     nemit_in    = nemit_ff + rtb_pkg::NEMIT_W'(1);
                  end
               end
               if (rd_ff != live_ff) begin
                  ram_re  = 1'b1;
                  rd_in   = rd_ff + CW'(1);
                  dvld_in = 1'b1;
               end else begin
                  dvld_in = 1'b0;
                  if (!dvld_ff) begin
                     state_in = S_END;
                  end
               end
            end
         end

         // Close the tick with the held firing, or a no-firing event.
         S_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (pend_ff) begin
                  rsp_kind_in    = rtb_pkg::KIND_FIRED;
                  rsp_id_in      = pend_id_ff;
                  rsp_removed_in = pend_rem_ff;
               end else begin
                  rsp_kind_in    = rtb_pkg::KIND_IDLE;
                  rsp_id_in      = '0;
                  rsp_removed_in = 1'b0;
               end
               pend_in  = 1'b0;
               live_in  = wr_ff;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         next_id_ff   <= '0;
         dvld_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         next_id_ff   <= next_id_in;
         dvld_ff      <= dvld_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and walk registers.
   always_ff @(posedge clock) begin
      req_period_ff  <= req_period_in;
      req_reps_ff    <= req_reps_in;
      dt_ff          <= dt_in;
      rd_ff          <= rd_in;
      wr_ff          <= wr_in;
      nemit_ff       <= nemit_in;
      pend_id_ff     <= pend_id_in;
      pend_rem_ff    <= pend_rem_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule
